// ===== rtl/dd_pkg.sv =====
`timescale 1ns / 1ps

package dd_pkg;

  // default sizing
  localparam int unsigned NumProcsDef = 8;
  localparam int unsigned NumResDef   = 4;

  // fixed field widths
  localparam int unsigned CmdW   = 2;
  localparam int unsigned ProcW  = 3;
  localparam int unsigned ResW   = 2;
  localparam int unsigned ValW   = 16;
  localparam int unsigned WorkW  = 20;

  typedef enum logic [CmdW-1:0] {
    CMD_LOAD_AVAIL = 2'd0,
    CMD_LOAD_ALLOC = 2'd1,
    CMD_LOAD_REQ   = 2'd2,
    CMD_RUN        = 2'd3
  } cmd_e;

  // one result beat
  typedef struct packed {
    logic [ProcW-1:0] proc_index_res;
    logic             deadlocked;
    logic             any_deadlock;
    logic             last;
  } res_t;

endpackage

// ===== rtl/dd_row_mem.sv =====
`timescale 1ns / 1ps

module dd_row_mem #(
  parameter int unsigned DEPTH     = dd_pkg::NumProcsDef,
  parameter int unsigned ROW_ELEMS = dd_pkg::NumResDef,
  parameter int unsigned ELEM_W    = dd_pkg::ValW
) (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              wr_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]       wr_row_i,
  input  logic [((ROW_ELEMS > 1) ? $clog2(ROW_ELEMS) : 1)-1:0] wr_col_i,
  input  logic [ELEM_W-1:0]                                 wr_data_i,
  input  logic                                              rd_en_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]       rd_row_i,
  output logic [ROW_ELEMS*ELEM_W-1:0]                       rd_data_o
);

  localparam int unsigned RowW  = ROW_ELEMS * ELEM_W;

  logic [RowW-1:0]  mem_q [DEPTH];
  logic [DEPTH-1:0] row_vld_q;
  logic [RowW-1:0]  fresh_row;
  logic [RowW-1:0]  rd_data_q;
  logic             rd_vld_q;

  // a row never written reads as zero; its first write fills the other columns with zero
  always_comb begin
    fresh_row = '0;
    fresh_row[wr_col_i*ELEM_W +: ELEM_W] = wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (wr_en_i) begin
        row_vld_q[wr_row_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= row_vld_q[rd_row_i];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      if (row_vld_q[wr_row_i]) begin
        mem_q[wr_row_i][wr_col_i*ELEM_W +: ELEM_W] <= wr_data_i;
      end else begin
        mem_q[wr_row_i] <= fresh_row;
      end
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_row_i];
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/dd_engine.sv =====
`timescale 1ns / 1ps

module dd_engine #(
  parameter int unsigned NUM_PROCS = dd_pkg::NumProcsDef,
  parameter int unsigned NUM_RES   = dd_pkg::NumResDef
) (
  input  logic                                             clk_i,
  input  logic                                             rst_ni,
  input  logic                                             start_i,
  input  logic [NUM_RES*dd_pkg::ValW-1:0]                  avail_i,
  input  logic [NUM_RES*dd_pkg::ValW-1:0]                  req_row_i,
  input  logic [NUM_RES*dd_pkg::ValW-1:0]                  alloc_row_i,
  output logic                                             rd_en_o,
  output logic [((NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1)-1:0] rd_row_o,
  output logic                                             busy_o,
  output logic                                             out_valid_o,
  input  logic                                             out_stall_i,
  output dd_pkg::res_t                                     out_o
);

  localparam int unsigned AddrW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned DoneW = $clog2(NUM_PROCS + 1);
  localparam int unsigned ValW  = dd_pkg::ValW;
  localparam int unsigned WorkW = dd_pkg::WorkW;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_EMIT = 3'b100
  } state_e;

  state_e                state_q, state_d;
  logic [WorkW-1:0]      work_q [NUM_RES];
  logic [WorkW-1:0]      work_d [NUM_RES];
  logic [NUM_PROCS-1:0]  fin_q;
  logic [DoneW-1:0]      done_q;
  logic [DoneW-1:0]      done_d;
  logic                  prog_q;
  logic                  pass_prog;
  logic [AddrW-1:0]      rd_row_q;
  logic [AddrW-1:0]      eval_row_q;
  logic                  eval_vld_q;
  logic                  may_go;
  logic                  fire;
  logic                  pass_end;
  logic [AddrW-1:0]      out_idx_q;
  logic                  any_q;
  logic                  out_vld_q;
  dd_pkg::res_t          out_q;
  logic                  out_load;
  logic                  out_last;
  logic [6:0]            out_idx_ext;
  logic [WorkW:0]        sum;

  // request compare and saturating release, one lane per resource
  always_comb begin
    may_go = !fin_q[eval_row_q];
    sum    = '0;
    for (int r = 0; r < NUM_RES; r++) begin
      if (WorkW'(req_row_i[r*ValW +: ValW]) > work_q[r]) begin
        may_go = 1'b0;
      end
    end
    fire = (state_q == ST_SCAN) && eval_vld_q && may_go;
    for (int r = 0; r < NUM_RES; r++) begin
      sum = (WorkW+1)'(work_q[r]) + (WorkW+1)'(alloc_row_i[r*ValW +: ValW]);
      if (fire) begin
        work_d[r] = sum[WorkW] ? {WorkW{1'b1}} : sum[WorkW-1:0];
      end else begin
        work_d[r] = work_q[r];
      end
    end
  end

  assign done_d    = done_q + DoneW'(fire);
  assign pass_prog = prog_q | fire;
  assign pass_end  = (state_q == ST_SCAN) && eval_vld_q &&
                     (eval_row_q == AddrW'(NUM_PROCS - 1));

  assign out_load    = (state_q == ST_EMIT) && (!out_vld_q || !out_stall_i);
  assign out_last    = (out_idx_q == AddrW'(NUM_PROCS - 1));
  assign out_idx_ext = 7'(out_idx_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (pass_end && !(pass_prog && (done_d != DoneW'(NUM_PROCS)))) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_load && out_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      fin_q      <= '0;
      done_q     <= '0;
      prog_q     <= 1'b0;
      rd_row_q   <= '0;
      eval_row_q <= '0;
      eval_vld_q <= 1'b0;
      out_idx_q  <= '0;
      any_q      <= 1'b0;
      out_vld_q  <= 1'b0;
      for (int r = 0; r < NUM_RES; r++) begin
        work_q[r] <= '0;
      end
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_IDLE: begin
          if (start_i) begin
            fin_q      <= '0;
            done_q     <= '0;
            prog_q     <= 1'b0;
            rd_row_q   <= '0;
            eval_vld_q <= 1'b0;
            for (int r = 0; r < NUM_RES; r++) begin
              work_q[r] <= WorkW'(avail_i[r*ValW +: ValW]);
            end
          end
        end
        ST_SCAN: begin
          rd_row_q   <= (rd_row_q == AddrW'(NUM_PROCS - 1)) ? '0 : rd_row_q + 1'b1;
          eval_row_q <= rd_row_q;
          eval_vld_q <= (state_d == ST_SCAN);
          done_q     <= done_d;
          work_q     <= work_d;
          if (fire) begin
            fin_q[eval_row_q] <= 1'b1;
          end
          prog_q <= pass_end ? 1'b0 : pass_prog;
          if (state_d == ST_EMIT) begin
            out_idx_q <= '0;
            any_q     <= (done_d != DoneW'(NUM_PROCS));
          end
        end
        ST_EMIT: begin
          if (out_load) begin
            out_idx_q <= out_last ? '0 : out_idx_q + 1'b1;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.proc_index_res <= out_idx_ext[dd_pkg::ProcW-1:0];
      out_q.deadlocked     <= !fin_q[out_idx_q];
      out_q.any_deadlock   <= any_q;
      out_q.last           <= out_last;
    end
  end

  assign rd_en_o     = (state_q == ST_SCAN);
  assign rd_row_o    = rd_row_q;
  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_vld_q;
  assign out_o       = out_q;

endmodule

// ===== rtl/deadlock_detector.sv =====
`timescale 1ns / 1ps
// load beat: written into the matrix memories or the available vector
// run beat: at most NUM_PROCS passes over the NUM_PROCS matrix rows, one row per cycle
//   read from the row memories through their read register, then NUM_PROCS result
//   beats through the output register
// a new beat is taken once the previous run has moved its last result into the output register
// reset (async, active low) clears control, the available vector and the row valid bits

module deadlock_detector #(
  parameter int unsigned NUM_PROCS = dd_pkg::NumProcsDef,
  parameter int unsigned NUM_RES   = dd_pkg::NumResDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // command channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [dd_pkg::CmdW-1:0]   in_cmd_i,
  input  logic [dd_pkg::ProcW-1:0]  in_proc_index_i,
  input  logic [dd_pkg::ResW-1:0]   in_res_index_i,
  input  logic [dd_pkg::ValW-1:0]   in_value_i,
  // result channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [dd_pkg::ProcW-1:0]  out_proc_index_res_o,
  output logic                      out_deadlocked_o,
  output logic                      out_any_deadlock_o,
  output logic                      out_last_o
);

  localparam int unsigned AddrW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
  localparam int unsigned ColW  = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
  localparam int unsigned ValW  = dd_pkg::ValW;
  localparam int unsigned RowW  = NUM_RES * ValW;

  logic              in_accept;
  logic [6:0]        proc_ext;
  logic [4:0]        res_ext;
  logic              proc_ok;
  logic              res_ok;
  logic [AddrW-1:0]  wr_row;
  logic [ColW-1:0]   wr_col;
  logic              alloc_we;
  logic              req_we;
  logic              run_start;
  logic [RowW-1:0]   avail_q;
  logic [RowW-1:0]   req_row;
  logic [RowW-1:0]   alloc_row;
  logic              rd_en;
  logic [AddrW-1:0]  rd_row;
  logic              busy;
  dd_pkg::res_t      res;

  // beats are taken only while the engine is idle, so loads never race a scan read
  assign in_stall_o = busy;
  assign in_accept  = in_valid_i && !in_stall_o;

  // out-of-range indexes are dropped
  assign proc_ext = 7'(in_proc_index_i);
  assign res_ext  = 5'(in_res_index_i);
  assign proc_ok  = (proc_ext < 7'(NUM_PROCS));
  assign res_ok   = (res_ext < 5'(NUM_RES));
  assign wr_row   = proc_ext[AddrW-1:0];
  assign wr_col   = res_ext[ColW-1:0];

  assign alloc_we  = in_accept && (in_cmd_i == dd_pkg::CMD_LOAD_ALLOC) && proc_ok && res_ok;
  assign req_we    = in_accept && (in_cmd_i == dd_pkg::CMD_LOAD_REQ) && proc_ok && res_ok;
  assign run_start = in_accept && (in_cmd_i == dd_pkg::CMD_RUN);

  // available vector sits in flops, copied whole into the working lanes at run start
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avail_q <= '0;
    end else if (in_accept && (in_cmd_i == dd_pkg::CMD_LOAD_AVAIL) && res_ok) begin
      avail_q[wr_col*ValW +: ValW] <= in_value_i;
    end
  end

  // allocation rows
  dd_row_mem #(
    .DEPTH     (NUM_PROCS),
    .ROW_ELEMS (NUM_RES),
    .ELEM_W    (ValW)
  ) u_alloc_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (alloc_we),
    .wr_row_i  (wr_row),
    .wr_col_i  (wr_col),
    .wr_data_i (in_value_i),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_data_o (alloc_row)
  );

  // request rows, read in lockstep with the allocation rows
  dd_row_mem #(
    .DEPTH     (NUM_PROCS),
    .ROW_ELEMS (NUM_RES),
    .ELEM_W    (ValW)
  ) u_req_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (req_we),
    .wr_row_i  (wr_row),
    .wr_col_i  (wr_col),
    .wr_data_i (in_value_i),
    .rd_en_i   (rd_en),
    .rd_row_i  (rd_row),
    .rd_data_o (req_row)
  );

  // scan sequencer: one row evaluated per cycle, then one result beat per process
  dd_engine #(
    .NUM_PROCS (NUM_PROCS),
    .NUM_RES   (NUM_RES)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (run_start),
    .avail_i     (avail_q),
    .req_row_i   (req_row),
    .alloc_row_i (alloc_row),
    .rd_en_o     (rd_en),
    .rd_row_o    (rd_row),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign out_proc_index_res_o = res.proc_index_res;
  assign out_deadlocked_o     = res.deadlocked;
  assign out_any_deadlock_o   = res.any_deadlock;
  assign out_last_o           = res.last;

`ifndef SYNTH
  // a deadlocked process always raises the summary flag
  a_any_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_deadlocked_o |-> out_any_deadlock_o)
    else $error("deadlocked beat without any_deadlock");

  // the final beat reports the highest process
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_last_o |-> out_proc_index_res_o == 3'(NUM_PROCS - 1))
    else $error("last beat on wrong process");

  // a run beat puts the engine to work
  a_run_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_cmd_i == dd_pkg::CMD_RUN |=> in_stall_o)
    else $error("run beat did not start the scan");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int NumProcs  = dd_pkg::NumProcsDef;
  localparam int NumRes    = dd_pkg::NumResDef;
  localparam int CmdW      = dd_pkg::CmdW;
  localparam int ProcW     = dd_pkg::ProcW;
  localparam int ResW      = dd_pkg::ResW;
  localparam int ValW      = dd_pkg::ValW;
  localparam int WorkW     = dd_pkg::WorkW;
  // a run is at most NumProcs passes of NumProcs rows, with no beat on either
  // side, then the result beats
  localparam int SettleCycles = 120;
  localparam int IdleLimit    = 2000;
  localparam int RandomBeats  = 437;
  localparam logic [WorkW-1:0] WorkMax = '1;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [CmdW-1:0]  in_cmd_i = dd_pkg::CMD_LOAD_AVAIL;
  logic [ProcW-1:0] in_proc_index_i = '0;
  logic [ResW-1:0]  in_res_index_i = '0;
  logic [ValW-1:0]  in_value_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [ProcW-1:0] out_proc_index_res_o;
  logic             out_deadlocked_o;
  logic             out_any_deadlock_o;
  logic             out_last_o;

  deadlock_detector DUT (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .in_cmd_i            (in_cmd_i),
    .in_proc_index_i     (in_proc_index_i),
    .in_res_index_i      (in_res_index_i),
    .in_value_i          (in_value_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_proc_index_res_o(out_proc_index_res_o),
    .out_deadlocked_o    (out_deadlocked_o),
    .out_any_deadlock_o  (out_any_deadlock_o),
    .out_last_o          (out_last_o)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // shadow copy of the stored vectors and of the scratch state of a run
  logic [ValW-1:0]     avail_units [NumRes] = '{default: '0};
  logic [ValW-1:0]     alloc_units [NumProcs][NumRes] = '{default: '{default: '0}};
  logic [ValW-1:0]     req_units   [NumProcs][NumRes] = '{default: '{default: '0}};
  logic [WorkW-1:0]    work_units  [NumRes] = '{default: '0};
  logic [NumProcs-1:0] proc_done = '0;

  dd_pkg::res_t expected_reports[$];
  int   error_count = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;

  // safety pass: repeat sweeps in index order until a sweep finishes nobody or all
  // are done, then queue one report per process
  function automatic void predict_detection_run();
    logic [WorkW:0] sum;
    bit             progress;
    bit             fits;
    bit             any_blocked;
    int             done;
    dd_pkg::res_t   rep;
    for (int r = 0; r < NumRes; r++) work_units[r] = WorkW'(avail_units[r]);
    proc_done = '0;
    done = 0;
    progress = 1'b1;
    while (progress && done != NumProcs) begin
      progress = 1'b0;
      for (int p = 0; p < NumProcs; p++) begin
        if (!proc_done[p]) begin
          fits = 1'b1;
          for (int r = 0; r < NumRes; r++) begin
            if (WorkW'(req_units[p][r]) > work_units[r]) fits = 1'b0;
          end
          if (fits) begin
            // returned units saturate at the top of the working width
            for (int r = 0; r < NumRes; r++) begin
              sum = work_units[r] + alloc_units[p][r];
              work_units[r] = (sum > WorkMax) ? WorkMax : sum[WorkW-1:0];
            end
            proc_done[p] = 1'b1;
            done++;
            progress = 1'b1;
          end
        end
      end
    end
    any_blocked = (done != NumProcs);
    for (int p = 0; p < NumProcs; p++) begin
      rep.proc_index_res = ProcW'(p);
      rep.deadlocked     = !proc_done[p];
      rep.any_deadlock   = any_blocked;
      rep.last           = (p == NumProcs - 1);
      expected_reports.push_back(rep);
    end
  endfunction

  function automatic void track_command(dd_pkg::cmd_e cmd, logic [ProcW-1:0] proc,
                                        logic [ResW-1:0] res, logic [ValW-1:0] val);
    case (cmd)
      // proc index plays no part in an available load
      dd_pkg::CMD_LOAD_AVAIL: avail_units[res] = val;
      dd_pkg::CMD_LOAD_ALLOC: alloc_units[proc][res] = val;
      dd_pkg::CMD_LOAD_REQ:   req_units[proc][res] = val;
      default:                predict_detection_run();
    endcase
  endfunction

  // unit counts: tiny at half the scales so that runs land on both sides of the safety
  // line, some mid sized, a few full range with the top value favored
  function automatic logic [ValW-1:0] pick_units(int scale);
    if (scale < 5) return ValW'($urandom_range(0, 3));
    if (scale < 8) return ValW'($urandom_range(0, 255));
    if ($urandom_range(0, 3) == 0) return '1;
    return ValW'($urandom_range(0, 65535));
  endfunction

  // one command beat; the sender runs in bursts with random gaps in between
  task automatic send_beat(dd_pkg::cmd_e cmd, logic [ProcW-1:0] proc, logic [ResW-1:0] res,
                           logic [ValW-1:0] val);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    in_valid_i      <= 1'b1;
    in_cmd_i        <= cmd;
    in_proc_index_i <= proc;
    in_res_index_i  <= res;
    in_value_i      <= val;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_command(cmd, proc, res, val);
    burst_left--;
  endtask

  // hold the sender off until every queued report has come back
  task automatic drain_reports();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_reports.size() != 0);
    burst_left = 0;
  endtask

  // nothing loaded yet: every request is zero, so everybody finishes
  task automatic test_empty_run();
    send_beat(dd_pkg::CMD_RUN, '0, '0, '0);
  endtask

  // a single unit asked for with nothing available blocks process 0
  task automatic test_blocked_process();
    send_beat(dd_pkg::CMD_LOAD_REQ, 3'd0, 2'd0, 16'd1);
    send_beat(dd_pkg::CMD_RUN, 3'd5, 2'd2, 16'h1234);
  endtask

  // process 7 frees the unit that process 0 waits for, so a second sweep is needed
  task automatic test_multi_pass();
    send_beat(dd_pkg::CMD_LOAD_ALLOC, 3'd7, 2'd0, 16'd1);
    send_beat(dd_pkg::CMD_RUN, '1, '1, '1);
  endtask

  // full-scale counts: a request equal to what is there fits, one freed
  // full allocation unlocks another, and all rows pile up on the last column
  task automatic test_full_scale();
    send_beat(dd_pkg::CMD_LOAD_AVAIL, 3'd7, 2'd3, 16'hFFFF);
    send_beat(dd_pkg::CMD_LOAD_REQ, 3'd2, 2'd3, 16'hFFFF);
    send_beat(dd_pkg::CMD_LOAD_ALLOC, 3'd1, 2'd2, 16'hFFFF);
    send_beat(dd_pkg::CMD_LOAD_REQ, 3'd4, 2'd2, 16'hFFFF);
    send_beat(dd_pkg::CMD_RUN, 3'd0, 2'd0, 16'd0);
    for (int p = 0; p < NumProcs; p++) begin
      send_beat(dd_pkg::CMD_LOAD_ALLOC, ProcW'(p), 2'd3, 16'hFFFF);
    end
    send_beat(dd_pkg::CMD_RUN, 3'd3, 2'd1, 16'h8000);
  endtask

  // back to back runs start from the stored vectors each time
  task automatic test_repeat_runs();
    send_beat(dd_pkg::CMD_RUN, 3'd1, 2'd1, 16'd0);
    send_beat(dd_pkg::CMD_RUN, 3'd6, 2'd2, 16'hFFFF);
    // nobody ever holds resource 1, so this request can never be met
    send_beat(dd_pkg::CMD_LOAD_REQ, 3'd1, 2'd1, 16'hFFFF);
    send_beat(dd_pkg::CMD_RUN, 3'd2, 2'd3, 16'h0F0F);
  endtask

  // random load sequences each closed by a run; a few runs come with few or
  // no loads before them, and after the twelfth run the sender waits for all reports
  task automatic test_random_sequences();
    int sent;
    int loads;
    int scale;
    int seq_count;
    sent = 0;
    seq_count = 0;
    while (sent < RandomBeats) begin
      loads = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 16);
      scale = $urandom_range(0, 9);
      repeat (loads) begin
        send_beat(dd_pkg::cmd_e'($urandom_range(0, 2)), ProcW'($urandom_range(0, 7)),
                  ResW'($urandom_range(0, 3)), pick_units(scale));
        sent++;
      end
      send_beat(dd_pkg::CMD_RUN, ProcW'($urandom_range(0, 7)), ResW'($urandom_range(0, 3)),
                ValW'($urandom_range(0, 65535)));
      sent++;
      seq_count++;
      if (seq_count == 12) drain_reports();
    end
  endtask

  // receiver stall: each time stall_tick wraps, the pattern is picked at random among none,
  // light random, a fixed period and heavy random
  int stall_mode = 0;
  int stall_tick = 0;
  always @(posedge clk_i) begin
    if (stall_tick == 49) begin
      stall_tick <= 0;
      stall_mode <= $urandom_range(0, 3);
    end else begin
      stall_tick <= stall_tick + 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ((stall_tick % 5) < 2);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // result check: each accepted beat against the oldest queued report
  always @(posedge clk_i) begin
    dd_pkg::res_t exp_rep;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected result beat for process %0d", out_proc_index_res_o);
        error_count++;
      end else begin
        exp_rep = expected_reports.pop_front();
        if (out_proc_index_res_o !== exp_rep.proc_index_res) begin
          $error("proc_index_res: expected %0d, got %0d",
                 exp_rep.proc_index_res, out_proc_index_res_o);
          error_count++;
        end
        if (out_deadlocked_o !== exp_rep.deadlocked) begin
          $error("deadlocked: expected %0d, got %0d", exp_rep.deadlocked, out_deadlocked_o);
          error_count++;
        end
        if (out_any_deadlock_o !== exp_rep.any_deadlock) begin
          $error("any_deadlock: expected %0d, got %0d",
                 exp_rep.any_deadlock, out_any_deadlock_o);
          error_count++;
        end
        if (out_last_o !== exp_rep.last) begin
          $error("last: expected %0d, got %0d", exp_rep.last, out_last_o);
          error_count++;
        end
      end
    end
  end

  // watchdog: too long without a beat on either channel means a hang
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IdleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_run();
    test_blocked_process();
    test_multi_pass();
    test_full_scale();
    test_repeat_runs();
    test_random_sequences();
    drain_reports();
    // room for any stray beat after the last report
    repeat (SettleCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
